/* src/pal_pkg.sv */
// ----------------------------------------------------------------------------
// Positional array list package
// Shared widths, operation and status codes, and the command and status
// structs that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package pal_pkg;

  localparam int unsigned CAPACITY_DEF = 128;

  localparam int unsigned OPCODE_W = 3;
  localparam int unsigned POS_W    = 8;
  localparam int unsigned VAL_W    = 32;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned FIDX_W   = 8;
  localparam int unsigned LEN_W    = 8;

  localparam logic [OPCODE_W-1:0] OP_INSERT  = 3'd0;
  localparam logic [OPCODE_W-1:0] OP_DELETE  = 3'd1;
  localparam logic [OPCODE_W-1:0] OP_REPLACE = 3'd2;
  localparam logic [OPCODE_W-1:0] OP_GET     = 3'd3;
  localparam logic [OPCODE_W-1:0] OP_FIND    = 3'd4;
  localparam logic [OPCODE_W-1:0] OP_CLEAR   = 3'd5;

  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_INS_FAIL = 2'd1;
  localparam logic [STATUS_W-1:0] ST_DEL_FAIL = 2'd2;
  localparam logic [STATUS_W-1:0] ST_RANGE    = 2'd3;

  // Commands from controller to datapath
  typedef struct packed {
    logic                load;        // latch position and value
    logic                idx_count;   // index <= length
    logic                idx_pos;     // index <= position
    logic                idx_zero;    // index <= 0
    logic                idx_inc;     // index <= index + 1
    logic                rd_pos;      // read entry at position
    logic                rd_src;      // read neighbour of index
    logic                rd_idx;      // read entry at index
    logic                dir_up;      // neighbour is index - 1 (insert)
    logic                wr_shift;    // entry[index] <= read data, index <= neighbour
    logic                wr_val;      // entry[position] <= value
    logic                cnt_inc;
    logic                cnt_dec;
    logic                cnt_clr;
    logic                finish;      // register the result and strobe it
    logic [STATUS_W-1:0] status;
    logic                take_rdata;
    logic                take_found;
    logic                take_absent;
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic ins_ok;      // room left and position within length
    logic in_range;    // position below length
    logic count_zero;
    logic ins_tail;    // insert at the end, nothing to move
    logic del_tail;    // delete of the last entry, nothing to move
    logic ins_last;    // final move of an insert
    logic del_last;    // final move of a delete
    logic find_last;   // index is the last entry
    logic match;       // read data equals key
  } sts_t;

endpackage

/* src/positional_array_list.sv */
// ----------------------------------------------------------------------------
// Positional array list
// Dense ordered list of signed 32-bit entries with insert, delete, replace,
// get, find and clear at a position, one result per item.
// ----------------------------------------------------------------------------
// Sequence (start accepted to done_o strobe, next start taken in the strobe cycle):
//   clear, replace, refused items, insert at the tail and delete of the tail finish
//   at decode; get reads the entry, then finishes; insert and delete move entries
//   and find probes them one at a time, and insert then writes the value. Each move
//   or probe is a registered read of the entry RAM, then a write or compare.
// Reset clears the length and the controller; the entry RAM is not cleared.
// The strobe cannot be held off: the result stays on the ports until the next one.
module positional_array_list #(
  parameter int unsigned CAPACITY = pal_pkg::CAPACITY_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  logic [pal_pkg::OPCODE_W-1:0]        opcode_i,
  input  logic [pal_pkg::POS_W-1:0]           position_i,
  input  logic signed [pal_pkg::VAL_W-1:0]    value_i,
  output logic                                done_o,
  output logic [pal_pkg::STATUS_W-1:0]        status_o,
  output logic signed [pal_pkg::VAL_W-1:0]    read_value_o,
  output logic signed [pal_pkg::FIDX_W-1:0]   found_index_o,
  output logic [pal_pkg::LEN_W-1:0]           list_length_o
);
  import pal_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // Sequence each item: decode, then walk the RAM one entry at a time
  pal_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .opcode_i (opcode_i),
    .sts_i    (sts),
    .cmd_o    (cmd),
    .busy     (busy)
  );

  // Hold the entries, the length and the registered result
  pal_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .position_i    (position_i),
    .value_i       (value_i),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .done_o        (done_o),
    .status_o      (status_o),
    .read_value_o  (read_value_o),
    .found_index_o (found_index_o),
    .list_length_o (list_length_o)
  );

endmodule

/* src/pal_ctrl.sv */
// ----------------------------------------------------------------------------
// Positional array list controller
// One-hot state machine that sequences each operation over the datapath.
// ----------------------------------------------------------------------------
module pal_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  input  logic [pal_pkg::OPCODE_W-1:0]  opcode_i,
  input  pal_pkg::sts_t                 sts_i,
  output pal_pkg::cmd_t                 cmd_o,
  output logic                          busy
);
  import pal_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE     = 8'b0000_0001,
    S_DECODE   = 8'b0000_0010,
    S_SH_RD    = 8'b0000_0100,
    S_SH_WR    = 8'b0000_1000,
    S_INS_WR   = 8'b0001_0000,
    S_GET_RD   = 8'b0010_0000,
    S_FIND_RD  = 8'b0100_0000,
    S_FIND_CMP = 8'b1000_0000
  } state_e;

  state_e               state_q, state_d;
  logic [OPCODE_W-1:0]  op_q, op_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      op_q    <= OP_INSERT;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
    end
  end

  assign busy = (state_q != S_IDLE);

  always_comb begin
    state_d = state_q;
    op_d    = op_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (start) begin
          op_d       = opcode_i;
          cmd_o.load = 1'b1;
          state_d    = S_DECODE;
        end
      end
      S_DECODE: begin
        state_d = S_IDLE;
        case (op_q)
          OP_INSERT: begin
            if (!sts_i.ins_ok) begin
              cmd_o.finish = 1'b1;
              cmd_o.status = ST_INS_FAIL;
            end else if (sts_i.ins_tail) begin
              cmd_o.wr_val  = 1'b1;
              cmd_o.cnt_inc = 1'b1;
              cmd_o.finish  = 1'b1;
            end else begin
              cmd_o.idx_count = 1'b1;
              state_d         = S_SH_RD;
            end
          end
          OP_DELETE: begin
            if (!sts_i.in_range) begin
              cmd_o.finish = 1'b1;
              cmd_o.status = ST_DEL_FAIL;
            end else if (sts_i.del_tail) begin
              cmd_o.cnt_dec = 1'b1;
              cmd_o.finish  = 1'b1;
            end else begin
              cmd_o.idx_pos = 1'b1;
              state_d       = S_SH_RD;
            end
          end
          OP_REPLACE: begin
            cmd_o.finish = 1'b1;
            if (sts_i.in_range) begin
              cmd_o.wr_val = 1'b1;
            end else begin
              cmd_o.status = ST_RANGE;
            end
          end
          OP_GET: begin
            if (sts_i.in_range) begin
              cmd_o.rd_pos = 1'b1;
              state_d      = S_GET_RD;
            end else begin
              cmd_o.finish = 1'b1;
              cmd_o.status = ST_RANGE;
            end
          end
          OP_FIND: begin
            if (sts_i.count_zero) begin
              cmd_o.finish      = 1'b1;
              cmd_o.take_absent = 1'b1;
            end else begin
              cmd_o.idx_zero = 1'b1;
              state_d        = S_FIND_RD;
            end
          end
          OP_CLEAR: begin
            cmd_o.cnt_clr = 1'b1;
            cmd_o.finish  = 1'b1;
          end
          default: begin
            cmd_o.finish = 1'b1;
          end
        endcase
      end
      S_SH_RD: begin
        cmd_o.rd_src = 1'b1;
        cmd_o.dir_up = (op_q == OP_INSERT);
        state_d      = S_SH_WR;
      end
      S_SH_WR: begin
        cmd_o.wr_shift = 1'b1;
        cmd_o.dir_up   = (op_q == OP_INSERT);
        state_d        = S_SH_RD;
        if (op_q == OP_INSERT) begin
          if (sts_i.ins_last) begin
            state_d = S_INS_WR;
          end
        end else if (sts_i.del_last) begin
          cmd_o.cnt_dec = 1'b1;
          cmd_o.finish  = 1'b1;
          state_d       = S_IDLE;
        end
      end
      S_INS_WR: begin
        cmd_o.wr_val  = 1'b1;
        cmd_o.cnt_inc = 1'b1;
        cmd_o.finish  = 1'b1;
        state_d       = S_IDLE;
      end
      S_GET_RD: begin
        cmd_o.finish     = 1'b1;
        cmd_o.take_rdata = 1'b1;
        state_d          = S_IDLE;
      end
      S_FIND_RD: begin
        cmd_o.rd_idx = 1'b1;
        state_d      = S_FIND_CMP;
      end
      S_FIND_CMP: begin
        if (sts_i.match) begin
          cmd_o.finish     = 1'b1;
          cmd_o.take_found = 1'b1;
          state_d          = S_IDLE;
        end else if (sts_i.find_last) begin
          cmd_o.finish      = 1'b1;
          cmd_o.take_absent = 1'b1;
          state_d           = S_IDLE;
        end else begin
          cmd_o.idx_inc = 1'b1;
          state_d       = S_FIND_RD;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

/* src/pal_dp.sv */
// ----------------------------------------------------------------------------
// Positional array list datapath
// Entry RAM with one write and one registered read port, length counter,
// walk index and result registers.
// ----------------------------------------------------------------------------
module pal_dp #(
  parameter int unsigned CAPACITY = pal_pkg::CAPACITY_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic [pal_pkg::POS_W-1:0]           position_i,
  input  logic signed [pal_pkg::VAL_W-1:0]    value_i,
  input  pal_pkg::cmd_t                       cmd_i,
  output pal_pkg::sts_t                       sts_o,
  output logic                                done_o,
  output logic [pal_pkg::STATUS_W-1:0]        status_o,
  output logic signed [pal_pkg::VAL_W-1:0]    read_value_o,
  output logic signed [pal_pkg::FIDX_W-1:0]   found_index_o,
  output logic [pal_pkg::LEN_W-1:0]           list_length_o
);
  import pal_pkg::*;

  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  localparam int unsigned IDX_W = $clog2(CAPACITY);
  localparam int unsigned CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

  logic [VAL_W-1:0]    mem_q [CAPACITY];
  logic [VAL_W-1:0]    rdata_q;
  logic [VAL_W-1:0]    val_q;
  logic [POS_W-1:0]    pos_q;
  logic [CNT_W-1:0]    count_q;
  logic [IDX_W-1:0]    idx_q;
  logic                done_q;
  logic [STATUS_W-1:0] status_q;
  logic [VAL_W-1:0]    read_value_q;
  logic [FIDX_W-1:0]   found_q;

  logic [CMP_W-1:0]    pos_w, count_w, idx_w;
  logic [IDX_W-1:0]    pos_idx, src_idx, rd_addr, wr_addr;
  logic [VAL_W-1:0]    wr_data;
  logic                rd_en, wr_en;

  assign pos_w   = CMP_W'(pos_q);
  assign count_w = CMP_W'(count_q);
  assign idx_w   = CMP_W'(idx_q);
  assign pos_idx = pos_w[IDX_W-1:0];
  assign src_idx = cmd_i.dir_up ? (idx_q - IDX_W'(1)) : (idx_q + IDX_W'(1));

  // Status for the controller
  assign sts_o.ins_ok     = (count_w < CMP_W'(CAPACITY)) && (pos_w <= count_w);
  assign sts_o.in_range   = (pos_w < count_w);
  assign sts_o.count_zero = (count_w == '0);
  assign sts_o.ins_tail   = (pos_w == count_w);
  assign sts_o.del_tail   = ((pos_w + CMP_W'(1)) == count_w);
  assign sts_o.ins_last   = ((idx_w - CMP_W'(1)) == pos_w);
  assign sts_o.del_last   = ((idx_w + CMP_W'(2)) == count_w);
  assign sts_o.find_last  = ((idx_w + CMP_W'(1)) == count_w);
  assign sts_o.match      = (rdata_q == val_q);

  // Single write port, single registered read port
  assign rd_en   = cmd_i.rd_pos | cmd_i.rd_src | cmd_i.rd_idx;
  assign rd_addr = cmd_i.rd_pos ? pos_idx : (cmd_i.rd_src ? src_idx : idx_q);
  assign wr_en   = cmd_i.wr_shift | cmd_i.wr_val;
  assign wr_addr = cmd_i.wr_shift ? idx_q : pos_idx;
  assign wr_data = cmd_i.wr_shift ? rdata_q : val_q;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_q <= mem_q[rd_addr];
    end
  end

  // Operands, walk index and result payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      pos_q <= position_i;
      val_q <= value_i;
    end
    if (cmd_i.idx_count) begin
      idx_q <= count_q[IDX_W-1:0];
    end else if (cmd_i.idx_pos) begin
      idx_q <= pos_idx;
    end else if (cmd_i.idx_zero) begin
      idx_q <= '0;
    end else if (cmd_i.wr_shift) begin
      idx_q <= src_idx;
    end else if (cmd_i.idx_inc) begin
      idx_q <= idx_q + IDX_W'(1);
    end
    if (cmd_i.finish) begin
      status_q     <= cmd_i.status;
      read_value_q <= cmd_i.take_rdata ? rdata_q : '0;
      if (cmd_i.take_found) begin
        found_q <= idx_w[FIDX_W-1:0];
      end else if (cmd_i.take_absent) begin
        found_q <= '1;
      end else begin
        found_q <= '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      done_q <= cmd_i.finish;
      if (cmd_i.cnt_clr) begin
        count_q <= '0;
      end else if (cmd_i.cnt_inc) begin
        count_q <= count_q + CNT_W'(1);
      end else if (cmd_i.cnt_dec) begin
        count_q <= count_q - CNT_W'(1);
      end
    end
  end

  assign done_o        = done_q;
  assign status_o      = status_q;
  assign read_value_o  = read_value_q;
  assign found_index_o = found_q;
  assign list_length_o = count_w[LEN_W-1:0];

endmodule

/* verif/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Positional array list testbench
// Drives insert, delete, replace, get, find, clear and the spare opcodes
// through the start/busy handshake. It keeps a shadow copy of the list,
// predicts the result of every accepted item and checks each strobed
// result against the oldest prediction, field by field.
// ----------------------------------------------------------------------------
module tb;
  import pal_pkg::*;

  localparam int unsigned LIST_CAP       = CAPACITY_DEF;
  localparam int unsigned CLK_PERIOD     = 10;
  localparam int unsigned RESET_CYCLES   = 10;
  localparam int unsigned RANDOM_ITEMS   = 800;
  localparam int unsigned PHASE_COUNT    = 4;
  // An insert or find over a near-full list walks the whole list; allow plenty more.
  localparam int unsigned WATCHDOG_LIMIT = 3000;
  localparam int unsigned SETTLE_CYCLES  = 300;
  localparam int unsigned MAX_REPORTS    = 10;

  // Opcodes the block treats as no operation.
  localparam logic [OPCODE_W-1:0] OP_SPARE_A = 3'd6;
  localparam logic [OPCODE_W-1:0] OP_SPARE_B = 3'd7;

  typedef struct packed {
    logic [OPCODE_W-1:0] op;
    logic [POS_W-1:0]    pos;
    logic [VAL_W-1:0]    val;
  } list_cmd_t;

  // One queued item plus how the driver should present it.
  typedef struct packed {
    list_cmd_t cmd;
    logic [6:0] gap_pct;  // chance, in percent, of an idle cycle before it
    logic       drain;    // hold it back until every result is in
  } list_job_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [VAL_W-1:0]    rd;
    logic [FIDX_W-1:0]   fidx;
    logic [LEN_W-1:0]    len;
  } list_result_t;

  // Clock, reset and block inputs all start at known values.
  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;
  logic start  = 1'b0;
  logic [OPCODE_W-1:0]     opcode_i   = '0;
  logic [POS_W-1:0]        position_i = '0;
  logic signed [VAL_W-1:0] value_i    = '0;

  logic                     busy;
  logic                     done_o;
  logic [STATUS_W-1:0]      status_o;
  logic signed [VAL_W-1:0]  read_value_o;
  logic signed [FIDX_W-1:0] found_index_o;
  logic [LEN_W-1:0]         list_length_o;

  positional_array_list #(
    .CAPACITY(LIST_CAP)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .opcode_i     (opcode_i),
    .position_i   (position_i),
    .value_i      (value_i),
    .done_o       (done_o),
    .status_o     (status_o),
    .read_value_o (read_value_o),
    .found_index_o(found_index_o),
    .list_length_o(list_length_o)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // Items waiting to be driven, and predictions waiting for their result.
  list_job_t    pending_q[$];
  list_result_t expected_q[$];

  // Shadow of the list contents and length, updated as items are accepted.
  logic [VAL_W-1:0] shadow_list[LIST_CAP];
  int unsigned      shadow_len = 0;

  // Length as the stimulus generator sees it, so that it can aim positions.
  int unsigned gen_len     = 0;
  int unsigned gen_items   = 0;
  int unsigned gap_now     = 0;
  logic        drain_next  = 1'b0;

  int unsigned n_issued     = 0;
  int unsigned n_taken      = 0;
  int unsigned n_mismatch   = 0;
  int unsigned quiet_cycles = 0;

  // Apply one item to the shadow list and return the result it must give.
  function automatic list_result_t predict_list_op(input list_cmd_t c);
    list_result_t r;
    int unsigned  i;
    logic         hit;
    r        = '0;
    r.status = ST_OK;
    hit      = 1'b0;
    case (c.op)
      OP_INSERT: begin
        if (shadow_len < LIST_CAP && c.pos <= shadow_len) begin
          // open the gap from the top down
          for (i = shadow_len; i > c.pos; i--) shadow_list[i] = shadow_list[i - 1];
          shadow_list[c.pos] = c.val;
          shadow_len++;
        end else begin
          r.status = ST_INS_FAIL;
        end
      end
      OP_DELETE: begin
        if (c.pos < shadow_len) begin
          for (i = c.pos + 1; i < shadow_len; i++) shadow_list[i - 1] = shadow_list[i];
          shadow_len--;
        end else begin
          r.status = ST_DEL_FAIL;
        end
      end
      OP_REPLACE: begin
        if (c.pos < shadow_len) shadow_list[c.pos] = c.val;
        else r.status = ST_RANGE;
      end
      OP_GET: begin
        if (c.pos < shadow_len) r.rd = shadow_list[c.pos];
        else r.status = ST_RANGE;
      end
      OP_FIND: begin
        // all ones means absent; the first hit wins
        r.fidx = '1;
        for (i = 0; i < shadow_len; i++) begin
          if (!hit && shadow_list[i] == c.val) begin
            r.fidx = i[FIDX_W-1:0];
            hit    = 1'b1;
          end
        end
      end
      OP_CLEAR: shadow_len = 0;
      default: ;
    endcase
    r.len = shadow_len[LEN_W-1:0];
    return r;
  endfunction

  // Mostly arbitrary words, often a few repeated ones so that finds hit.
  function automatic logic [VAL_W-1:0] pick_value();
    logic [VAL_W-1:0] pool[8];
    pool = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
             32'h0000_0001, 32'h5555_5555, 32'hAAAA_AAAA, 32'h0000_002A};
    if ($urandom_range(2) == 0) return pool[$urandom_range(7)];
    return $urandom;
  endfunction

  // Queue one item and track the length it leaves behind.
  task automatic queue_op(input logic [OPCODE_W-1:0] op, input int unsigned pos,
                          input logic [VAL_W-1:0] val);
    list_job_t j;
    j.cmd.op   = op;
    j.cmd.pos  = pos[POS_W-1:0];
    j.cmd.val  = val;
    j.gap_pct  = gap_now[6:0];
    j.drain    = drain_next;
    drain_next = 1'b0;
    pending_q.push_back(j);
    gen_items++;
    case (op)
      OP_INSERT: if (gen_len < LIST_CAP && pos <= gen_len) gen_len++;
      OP_DELETE: if (pos < gen_len) gen_len--;
      OP_CLEAR:  gen_len = 0;
      default: ;
    endcase
  endtask

  // Grow the list to capacity at random positions, then push past it.
  task automatic queue_fill();
    while (gen_len < LIST_CAP) queue_op(OP_INSERT, $urandom_range(gen_len), pick_value());
    queue_op(OP_INSERT, $urandom_range(gen_len), pick_value());
    queue_op(OP_INSERT, $urandom_range(255), pick_value());
  endtask

  task automatic report_field(input string what, input logic [VAL_W-1:0] want,
                              input logic [VAL_W-1:0] got);
    n_mismatch++;
    if (n_mismatch <= MAX_REPORTS)
      $display("%0t ns: %s mismatch: expected %h, got %h", $time, what, want, got);
  endtask

  // --------------------------------------------------------------------------
  // Driver: change inputs on the falling edge only. Hold an item until the
  // block takes it; drop start when the pacing says idle, when a drain item
  // must wait for the block to empty, or when nothing is left to send.
  // --------------------------------------------------------------------------
  always @(negedge clk_i) begin : drive_items
    list_job_t job;
    if (rst_ni && (!start || n_taken == n_issued)) begin
      if (pending_q.size() != 0
          && !(pending_q[0].drain && expected_q.size() != 0)
          && $urandom_range(99) >= pending_q[0].gap_pct) begin
        job        = pending_q.pop_front();
        opcode_i   <= job.cmd.op;
        position_i <= job.cmd.pos;
        value_i    <= job.cmd.val;
        start      <= 1'b1;
        n_issued   <= n_issued + 1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: sample on the rising edge. Check a strobed result against the
  // oldest prediction before predicting the item taken at the same edge, so
  // that back-to-back traffic keeps its order. The watchdog counts edges at
  // which nothing moves in either direction.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin : watch_results
    list_result_t want;
    list_cmd_t    took;
    if (rst_ni) begin
      if (done_o) begin
        if (expected_q.size() == 0) begin
          report_field("unexpected result, status", '0, VAL_W'(status_o));
        end else begin
          want = expected_q.pop_front();
          if (status_o !== want.status)
            report_field("status", VAL_W'(want.status), VAL_W'(status_o));
          if (read_value_o !== want.rd)
            report_field("read_value", want.rd, read_value_o);
          if (found_index_o !== want.fidx)
            report_field("found_index", VAL_W'(want.fidx), VAL_W'(found_index_o));
          if (list_length_o !== want.len)
            report_field("list_length", VAL_W'(want.len), VAL_W'(list_length_o));
        end
      end
      if (start && !busy) begin
        took.op  = opcode_i;
        took.pos = position_i;
        took.val = value_i;
        expected_q.push_back(predict_list_op(took));
        n_taken <= n_taken + 1;
      end
      if (done_o || (start && !busy)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus: build the whole item stream up front, release reset, then wait
  // for the stream and every result to drain before the verdict.
  // --------------------------------------------------------------------------
  initial begin : run_list_test
    int unsigned phase_gap[PHASE_COUNT];
    int unsigned phase;
    int unsigned roll;
    int unsigned pos;
    logic [OPCODE_W-1:0] op;

    // Pacing per phase: back to back, sparse, back to back again, light gaps.
    phase_gap = '{0, 65, 0, 9};

    // Directed: the empty list first, so every refusal shows up.
    queue_op(OP_FIND,    0, 32'h0000_0000);  // absent on an empty list
    queue_op(OP_GET,     0, 32'h0000_0000);
    queue_op(OP_REPLACE, 0, 32'h1111_1111);
    queue_op(OP_DELETE,  0, 32'h0000_0000);
    queue_op(OP_INSERT,  1, 32'h0000_0000);  // beyond the length
    // Build a small list through front, tail and middle inserts.
    queue_op(OP_INSERT,  0, 32'h7FFF_FFFF);
    queue_op(OP_INSERT,  0, 32'h8000_0000);
    queue_op(OP_INSERT,  2, 32'h0000_0000);
    queue_op(OP_INSERT,  1, 32'hFFFF_FFFF);
    queue_op(OP_GET,     0, 32'h0000_0000);
    queue_op(OP_GET,     1, 32'h0000_0000);
    queue_op(OP_GET,     3, 32'h0000_0000);
    queue_op(OP_FIND,    0, 32'h0000_0000);
    queue_op(OP_FIND,    0, 32'hFFFF_FFFF);
    queue_op(OP_FIND,    0, 32'h0001_E240);  // not in the list
    queue_op(OP_REPLACE, 3, 32'h1234_5678);
    queue_op(OP_GET,     3, 32'h0000_0000);
    queue_op(OP_GET,     4, 32'h0000_0000);  // at the length
    queue_op(OP_GET,   255, 32'hFFFF_FFFF);  // far beyond it
    queue_op(OP_DELETE,  1, 32'h0000_0000);
    queue_op(OP_DELETE,  0, 32'h0000_0000);
    queue_op(OP_DELETE, gen_len - 1, 32'h0000_0000);
    queue_op(OP_SPARE_A, 0, 32'h0000_0000);
    queue_op(OP_SPARE_B, 255, 32'hFFFF_FFFF);
    queue_op(OP_CLEAR,   0, 32'h0000_0000);
    queue_op(OP_GET,     0, 32'h0000_0000);

    // Random phases. Each opens by draining the block; the odd ones fill the
    // list to capacity first so that the full case and long moves are hit.
    for (phase = 0; phase < PHASE_COUNT; phase++) begin
      gap_now    = phase_gap[phase];
      drain_next = 1'b1;
      gen_items  = 0;
      if (phase % 2 == 1) queue_fill();
      while (gen_items < RANDOM_ITEMS / PHASE_COUNT) begin
        roll = $urandom_range(999);
        if (roll < 5) begin
          queue_fill();
        end else if (roll < 10) begin
          // empty it one delete at a time, then one refused delete
          while (gen_len > 0) queue_op(OP_DELETE, $urandom_range(gen_len - 1), pick_value());
          queue_op(OP_DELETE, $urandom_range(255), pick_value());
        end else begin
          if (roll < 20) drain_next = 1'b1;
          roll = $urandom_range(99);
          if (roll < 32)      op = OP_INSERT;
          else if (roll < 54) op = OP_DELETE;
          else if (roll < 64) op = OP_REPLACE;
          else if (roll < 78) op = OP_GET;
          else if (roll < 92) op = OP_FIND;
          else if (roll < 94) op = OP_CLEAR;
          else op = $urandom_range(1) ? OP_SPARE_A : OP_SPARE_B;
          // aim most positions inside the list, some anywhere in the field
          if ($urandom_range(9) == 0) pos = $urandom_range(255);
          else if (op == OP_INSERT) pos = $urandom_range(gen_len);
          else if (gen_len == 0) pos = $urandom_range(255);
          else pos = $urandom_range(gen_len - 1);
          queue_op(op, pos, pick_value());
        end
      end
    end

    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Wait for every item to go in and every result to come back, then give
    // the block time to show any stray strobe.
    while (pending_q.size() != 0 || n_taken != n_issued) @(negedge clk_i);
    while (expected_q.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);

    if (n_mismatch == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
